// ===== rtl/ppmcd_pkg.sv =====
package ppmcd_pkg;

  localparam int CNT_W      = 24;
  localparam int VAL_W      = 12;
  localparam int IDX_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0] COUNTER_MAX = {CNT_W{1'b1}};

  localparam int CHANNEL_COUNT_DEF = 12;
  localparam int TICKS_PER_US_DEF  = 200;

  localparam logic [CNT_W-1:0] SYNC_GAP_RESET     = CNT_W'(344000);
  localparam logic [VAL_W-1:0] PULSE_OFFSET_RESET = VAL_W'(300);
  localparam logic [VAL_W-1:0] CLAMP_LOW_RESET    = VAL_W'(1000);
  localparam logic [VAL_W-1:0] CLAMP_HIGH_RESET   = VAL_W'(2000);
  localparam logic [VAL_W-1:0] STORE_RESET        = VAL_W'(1000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SYNC_GAP     = 2'd0,
    REG_PULSE_OFFSET = 2'd1,
    REG_CLAMP_LOW    = 2'd2,
    REG_CLAMP_HIGH   = 2'd3
  } cfg_reg_t;

  // Edge classification of one sample, with the measured low time.
  typedef struct packed {
    logic             valid;
    logic             store_en;
    logic             sync;
    logic             snap;
    logic [CNT_W-1:0] width;
  } edge_req_t;

  // Same request after the tick count has been scaled to microseconds.
  typedef struct packed {
    logic             valid;
    logic             store_en;
    logic             sync;
    logic             snap;
    logic [CNT_W-1:0] quotient;
  } scale_req_t;

endpackage

// ===== rtl/ppmcd_edge_timer.sv =====
module ppmcd_edge_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        pin_level,
  input  logic                        snapshot_request,
  input  logic [ppmcd_pkg::CNT_W-1:0] sync_gap_ticks,
  output ppmcd_pkg::edge_req_t        req
);
  import ppmcd_pkg::*;

  logic             previous_level;
  logic [CNT_W-1:0] tick_counter;
  logic [CNT_W-1:0] tick_counter_next;
  edge_req_t        req_next;

  always_comb begin
    req_next          = '0;
    req_next.valid    = accept;
    req_next.snap     = accept & snapshot_request;
    req_next.width    = tick_counter;
    tick_counter_next = tick_counter;
    if (pin_level != previous_level) begin
      tick_counter_next = '0;
      if (pin_level) begin
        req_next.sync     = accept & (tick_counter > sync_gap_ticks);
        req_next.store_en = accept & ~(tick_counter > sync_gap_ticks);
      end
    end else if (tick_counter != COUNTER_MAX) begin
      tick_counter_next = tick_counter + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      tick_counter   <= '0;
    end else if (accept) begin
      previous_level <= pin_level;
      tick_counter   <= tick_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid    <= 1'b0;
      req.store_en <= 1'b0;
      req.sync     <= 1'b0;
      req.snap     <= 1'b0;
    end else begin
      req.valid    <= req_next.valid;
      req.store_en <= req_next.store_en;
      req.sync     <= req_next.sync;
      req.snap     <= req_next.snap;
    end
    req.width <= req_next.width;
  end

endmodule

// ===== rtl/ppmcd_scaler.sv =====
module ppmcd_scaler #(
  parameter int TICKS_PER_US = ppmcd_pkg::TICKS_PER_US_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ppmcd_pkg::edge_req_t        req_in,
  input  logic [ppmcd_pkg::VAL_W-1:0] pulse_offset_us,
  input  logic [ppmcd_pkg::VAL_W-1:0] clamp_low_us,
  input  logic [ppmcd_pkg::VAL_W-1:0] clamp_high_us,
  output ppmcd_pkg::scale_req_t       req_out,
  output logic [ppmcd_pkg::VAL_W-1:0] value
);
  import ppmcd_pkg::*;

  // Division by a constant as multiply by a rounded-up reciprocal; exact for
  // every dividend of CNT_W bits.
  localparam int              SHIFT_L = $clog2(TICKS_PER_US);
  localparam int              SHIFT   = CNT_W + SHIFT_L;
  localparam longint unsigned RECIP   =
    ((64'd1 << SHIFT) + longint'(TICKS_PER_US) - 64'd1) / longint'(TICKS_PER_US);
  localparam int              RECIP_W = CNT_W + 1;
  localparam int              PROD_W  = CNT_W + RECIP_W;
  localparam logic [PROD_W-1:0] RECIP_EXT = PROD_W'(RECIP[RECIP_W-1:0]);

  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] product_shifted;
  logic [CNT_W:0]    sum;

  assign product         = PROD_W'(req_in.width) * RECIP_EXT;
  assign product_shifted = product >> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_out.valid    <= 1'b0;
      req_out.store_en <= 1'b0;
      req_out.sync     <= 1'b0;
      req_out.snap     <= 1'b0;
    end else begin
      req_out.valid    <= req_in.valid;
      req_out.store_en <= req_in.store_en;
      req_out.sync     <= req_in.sync;
      req_out.snap     <= req_in.snap;
    end
    req_out.quotient <= product_shifted[CNT_W-1:0];
  end

  assign sum = {1'b0, req_out.quotient} + (CNT_W+1)'(pulse_offset_us);

  // The high bound is tested first; with crossed bounds, only sums above it take it.
  always_comb begin
    priority if (sum > (CNT_W+1)'(clamp_high_us)) begin
      value = clamp_high_us;
    end else if (sum < (CNT_W+1)'(clamp_low_us)) begin
      value = clamp_low_us;
    end else begin
      value = sum[VAL_W-1:0];
    end
  end

endmodule

// ===== rtl/ppmcd_channel_store.sv =====
module ppmcd_channel_store #(
  parameter int CHANNEL_COUNT = ppmcd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  ppmcd_pkg::scale_req_t                           req,
  input  logic [ppmcd_pkg::VAL_W-1:0]                     value,
  output logic [CHANNEL_COUNT-1:0][ppmcd_pkg::VAL_W-1:0]  store
);
  import ppmcd_pkg::*;

  localparam int PTR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CHANNEL_COUNT - 1);

  logic [PTR_W-1:0] channel_pointer;
  logic [PTR_W-1:0] channel_pointer_next;

  always_comb begin
    channel_pointer_next = channel_pointer;
    priority if (req.valid && req.sync) begin
      channel_pointer_next = '0;
    end else if (req.valid && req.store_en) begin
      channel_pointer_next = (channel_pointer == PTR_LAST) ? '0
                                                           : channel_pointer + PTR_W'(1);
    end else begin
      channel_pointer_next = channel_pointer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pointer <= '0;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        store[k] <= STORE_RESET;
      end
    end else begin
      channel_pointer <= channel_pointer_next;
      if (req.valid && req.store_en) begin
        store[channel_pointer] <= value;
      end
    end
  end

endmodule

// ===== rtl/ppmcd_burst_out.sv =====
module ppmcd_burst_out #(
  parameter int CHANNEL_COUNT = ppmcd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           load,
  input  logic [CHANNEL_COUNT-1:0][ppmcd_pkg::VAL_W-1:0] values,
  output logic                                           busy,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [ppmcd_pkg::IDX_W-1:0]                    channel_index,
  output logic [ppmcd_pkg::VAL_W-1:0]                    channel_value,
  output logic                                           last_of_burst
);
  import ppmcd_pkg::*;

  localparam int PTR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CHANNEL_COUNT - 1);

  logic [CHANNEL_COUNT-1:0][VAL_W-1:0] snap_buf;
  logic [PTR_W-1:0]                    burst_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      burst_idx <= '0;
    end else if (load) begin
      busy      <= 1'b1;
      burst_idx <= '0;
    end else if (busy && out_ready) begin
      if (burst_idx == PTR_LAST) begin
        busy <= 1'b0;
      end
      burst_idx <= (burst_idx == PTR_LAST) ? '0 : burst_idx + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_buf <= values;
    end
  end

  assign out_valid     = busy;
  assign channel_index = IDX_W'(burst_idx);
  assign channel_value = snap_buf[burst_idx];
  assign last_of_burst = (burst_idx == PTR_LAST);

endmodule

// ===== rtl/ppm_channel_decoder_core.sv =====
// Pipeline: an accepted sample is registered in the edge timer, then in the scaler;
// its channel update is then written to the store, and any snapshot loaded with it.
// Throughput: one sample per cycle while in_ready is high; a snapshot holds the
// output for CHANNEL_COUNT transfers; another snapshot request waits until it drains.
// Reset (rst, synchronous): registers to their defaults, counter and pointer to zero,
// every channel to 1000 us, no output pending.
module ppm_channel_decoder_core #(
  parameter int CHANNEL_COUNT = ppmcd_pkg::CHANNEL_COUNT_DEF,
  parameter int TICKS_PER_US  = ppmcd_pkg::TICKS_PER_US_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppmcd_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [ppmcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             pin_level,
  input  logic                             snapshot_request,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppmcd_pkg::IDX_W-1:0]      channel_index,
  output logic [ppmcd_pkg::VAL_W-1:0]      channel_value,
  output logic                             last_of_burst
);
  import ppmcd_pkg::*;

  logic [CNT_W-1:0] sync_gap_ticks;
  logic [VAL_W-1:0] pulse_offset_us;
  logic [VAL_W-1:0] clamp_low_us;
  logic [VAL_W-1:0] clamp_high_us;

  logic       accept;
  logic       busy;
  edge_req_t  edge_req;
  scale_req_t scale_req;
  logic [VAL_W-1:0]                    value;
  logic [CHANNEL_COUNT-1:0][VAL_W-1:0] store;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_gap_ticks  <= SYNC_GAP_RESET;
      pulse_offset_us <= PULSE_OFFSET_RESET;
      clamp_low_us    <= CLAMP_LOW_RESET;
      clamp_high_us   <= CLAMP_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SYNC_GAP:     sync_gap_ticks  <= cfg_data[CNT_W-1:0];
        REG_PULSE_OFFSET: pulse_offset_us <= cfg_data[VAL_W-1:0];
        REG_CLAMP_LOW:    clamp_low_us    <= cfg_data[VAL_W-1:0];
        REG_CLAMP_HIGH:   clamp_high_us   <= cfg_data[VAL_W-1:0];
      endcase
    end
  end

  // Only one snapshot may be in flight, from acceptance until its last value leaves.
  assign in_ready = ~(snapshot_request & (edge_req.snap | scale_req.snap | busy));
  assign accept   = in_valid & in_ready;

  ppmcd_edge_timer u_edge_timer (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .pin_level        (pin_level),
    .snapshot_request (snapshot_request),
    .sync_gap_ticks   (sync_gap_ticks),
    .req              (edge_req)
  );

  ppmcd_scaler #(
    .TICKS_PER_US (TICKS_PER_US)
  ) u_scaler (
    .clk             (clk),
    .rst             (rst),
    .req_in          (edge_req),
    .pulse_offset_us (pulse_offset_us),
    .clamp_low_us    (clamp_low_us),
    .clamp_high_us   (clamp_high_us),
    .req_out         (scale_req),
    .value           (value)
  );

  ppmcd_channel_store #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_channel_store (
    .clk   (clk),
    .rst   (rst),
    .req   (scale_req),
    .value (value),
    .store (store)
  );

  // The snapshot copies the store in the same cycle that this sample's write lands,
  // so it holds the values from before the update.
  ppmcd_burst_out #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_burst_out (
    .clk           (clk),
    .rst           (rst),
    .load          (scale_req.valid & scale_req.snap),
    .values        (store),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_of_burst (last_of_burst)
  );

endmodule

// ===== tb/ppm_channel_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module ppm_channel_decoder_core_tb;
  import ppmcd_pkg::*;

  localparam int NUM_CH = CHANNEL_COUNT_DEF;
  localparam int TICKS  = TICKS_PER_US_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } chan_result_t;

  typedef struct packed {
    logic             pin;
    logic             snap;
    logic [15:0]      reps;
    logic             has_typed;
    logic [VAL_W-1:0] typed_us;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  pin_level = 1'b0;
  logic                  snapshot_request = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [IDX_W-1:0]      channel_index;
  logic [VAL_W-1:0]      channel_value;
  logic                  last_of_burst;

  // Decoder state as seen from the line, stepped once per accepted sample.
  logic             prev_pin;
  logic [CNT_W-1:0] gap_ticks;
  int unsigned      chan_ptr;
  logic [VAL_W-1:0] chan_us [NUM_CH];
  logic [CNT_W-1:0] sync_gap_cfg;
  logic [VAL_W-1:0] offset_cfg;
  logic [VAL_W-1:0] clamp_lo_cfg;
  logic [VAL_W-1:0] clamp_hi_cfg;

  chan_result_t expected_channels [$];
  int           errors = 0;
  int           samples = 0;
  int           values_checked = 0;
  int           settings = 0;
  bit           idle_en = 1'b1;

  // The first rows are checked against values typed in; the rest against the decoder state.
  // The low run of the second row ends in a gap of exactly one microsecond.
  stim_row_t directed_rows [8] = '{
    '{1'b0, 1'b1, 16'd1,   1'b1, 12'd1000},
    '{1'b0, 1'b0, 16'd199, 1'b0, 12'd0},
    '{1'b1, 1'b1, 16'd1,   1'b1, 12'd1000},
    '{1'b0, 1'b1, 16'd1,   1'b0, 12'd0},
    '{1'b1, 1'b0, 16'd1,   1'b0, 12'd0},
    '{1'b1, 1'b0, 16'd3,   1'b0, 12'd0},
    '{1'b0, 1'b0, 16'd1,   1'b0, 12'd0},
    '{1'b1, 1'b1, 16'd1,   1'b0, 12'd0}
  };

  ppm_channel_decoder_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pin_level        (pin_level),
    .snapshot_request (snapshot_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .channel_index    (channel_index),
    .channel_value    (channel_value),
    .last_of_burst    (last_of_burst)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= !idle_en || ($urandom_range(0, 99) >= 15);
  end

  function automatic logic [VAL_W-1:0] clamp_us(input int unsigned us);
    // The high bound is tested first; with crossed bounds, only values above it take it.
    if (us > clamp_hi_cfg) return clamp_hi_cfg;
    if (us < clamp_lo_cfg) return clamp_lo_cfg;
    return us[VAL_W-1:0];
  endfunction

  task automatic reset_decoder();
    prev_pin     = 1'b0;
    gap_ticks    = '0;
    chan_ptr     = 0;
    sync_gap_cfg = SYNC_GAP_RESET;
    offset_cfg   = PULSE_OFFSET_RESET;
    clamp_lo_cfg = CLAMP_LOW_RESET;
    clamp_hi_cfg = CLAMP_HIGH_RESET;
    foreach (chan_us[k]) chan_us[k] = STORE_RESET;
  endtask

  task automatic decode_sample(input logic pin, input logic snap, input bit emit);
    chan_result_t r;
    int unsigned  us;
    // A snapshot shows the channels as they stood before this sample.
    if (snap && emit) begin
      for (int k = 0; k < NUM_CH; k++) begin
        r.index = k[IDX_W-1:0];
        r.value = chan_us[k];
        r.last  = (k == NUM_CH - 1);
        expected_channels.push_back(r);
      end
    end
    if (pin != prev_pin) begin
      if (pin) begin
        if (gap_ticks > sync_gap_cfg) begin
          chan_ptr = 0;
        end else begin
          us = gap_ticks / TICKS + offset_cfg;
          chan_us[chan_ptr] = clamp_us(us);
          chan_ptr = (chan_ptr + 1) % NUM_CH;
        end
      end
      gap_ticks = '0;
    end else if (gap_ticks != COUNTER_MAX) begin
      gap_ticks++;
    end
    prev_pin = pin;
  endtask

  // Called at a falling edge; leaves the write enable high for the caller to drop.
  task automatic write_reg(input cfg_reg_t r, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= data[CFG_DATA_W-1:0];
    case (r)
      REG_SYNC_GAP:     sync_gap_cfg = data[CNT_W-1:0];
      REG_PULSE_OFFSET: offset_cfg   = data[VAL_W-1:0];
      REG_CLAMP_LOW:    clamp_lo_cfg = data[VAL_W-1:0];
      REG_CLAMP_HIGH:   clamp_hi_cfg = data[VAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input int unsigned sync_gap, input int unsigned offset,
                            input int unsigned lo, input int unsigned hi);
    write_reg(REG_SYNC_GAP, sync_gap);
    write_reg(REG_PULSE_OFFSET, offset);
    write_reg(REG_CLAMP_LOW, lo);
    write_reg(REG_CLAMP_HIGH, hi);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_sample(input logic pin, input logic snap, input bit emit = 1'b1);
    while (idle_en && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    pin_level        <= pin;
    snapshot_request <= snap;
    do @(posedge clk); while (!in_ready);
    decode_sample(pin, snap, emit);
    samples++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_sample(level, (i == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) == 0));
    end
  endtask

  // Short frames: low gap then a short high pulse, with some line noise.
  task automatic run_phase(input int unsigned pulses);
    int unsigned kind;
    int unsigned len;
    for (int p = 0; p < pulses; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(2, 4)) begin
          send_sample($urandom_range(0, 1) == 1, $urandom_range(0, 9) == 0);
        end
      end else begin
        // Sync-length gaps land on the threshold and just past it.
        if (kind < 35 && sync_gap_cfg < 8) len = sync_gap_cfg + $urandom_range(1, 3);
        else len = $urandom_range(1, 6);
        send_run(1'b0, len);
        send_run(1'b1, $urandom_range(1, 3));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    chan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_channels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got index %0d value %0d last %0b",
                 $time, channel_index, channel_value, last_of_burst);
      end else begin
        want = expected_channels.pop_front();
        values_checked++;
        if (channel_index !== want.index) begin
          errors++;
          $display("%0t: channel_index expected %0d, got %0d", $time, want.index, channel_index);
        end
        if (channel_value !== want.value) begin
          errors++;
          $display("%0t: channel_value of channel %0d expected %0d, got %0d",
                   $time, want.index, want.value, channel_value);
        end
        if (last_of_burst !== want.last) begin
          errors++;
          $display("%0t: last_of_burst of channel %0d expected %0b, got %0b",
                   $time, want.index, want.last, last_of_burst);
        end
      end
    end
  end

  initial begin
    int unsigned off;
    int unsigned lo;
    chan_result_t r;
    reset_decoder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Largest offset with a one-microsecond gap overflows twelve bits before the clamp.
    // The directed part runs with no idling on either side.
    set_config(24'hFFFFFF, 4095, 0, 4095);
    idle_en = 1'b0;
    foreach (directed_rows[i]) begin
      for (int n = 0; n < directed_rows[i].reps; n++) begin
        if (directed_rows[i].has_typed && directed_rows[i].snap) begin
          for (int k = 0; k < NUM_CH; k++) begin
            r.index = k[IDX_W-1:0];
            r.value = directed_rows[i].typed_us;
            r.last  = (k == NUM_CH - 1);
            expected_channels.push_back(r);
          end
        end
        send_sample(directed_rows[i].pin, directed_rows[i].snap,
                    !(directed_rows[i].has_typed && directed_rows[i].snap));
      end
    end
    drain();
    idle_en = 1'b1;

    // The offset lies below the clamp window, so stored values rise to the low bound.
    set_config(4, 1000, 1003, 1008);
    run_phase(2);
    drain();

    set_config(0, 0, 0, 4095);
    run_phase(2);
    drain();

    set_config(3, 4095, 4095, 0);
    run_phase(2);
    drain();

    set_config(24'hFFFFFF, $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095));
    run_phase(2);
    drain();

    off = $urandom_range(0, 4079);
    lo  = off + $urandom_range(0, 8);
    set_config($urandom_range(1, 6), off, lo, lo + $urandom_range(0, 8));
    run_phase(2);
    drain();

    $display("Decoded %0d line samples under %0d register settings.", samples, settings);
    $display("Compared %0d snapshot channel values, %0d mismatches.", values_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
